// ===== src/circular_ordered_list_engine_core_defines.svh =====
// Assertion macros shared by the RTL of the circular ordered list engine.
`ifndef CIRCULAR_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define CIRCULAR_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define COL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define COL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COL_ASSERT(label, prop, msg)
`define COL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/colist_pkg.sv =====
`timescale 1ns / 1ps

package colist_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } opcode_t;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_DUMPED    = 3'd5;

    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic val_we;
    } mem_ctl_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] element_value;
        logic        last_of_run;
        logic [5:0]  length;
    } result_t;

endpackage

// ===== src/colist_mem.sv =====
`timescale 1ns / 1ps

module colist_mem #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        clk,
    input  colist_pkg::mem_ctl_t        ctl,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] link_addr,
    input  logic [$clog2(CAPACITY)-1:0] link_wdata,
    input  logic [$clog2(CAPACITY)-1:0] val_addr,
    input  logic [VALUE_WIDTH-1:0]      val_wdata,
    output logic [$clog2(CAPACITY)-1:0] rd_link,
    output logic [VALUE_WIDTH-1:0]      rd_val
);

    localparam int AW = $clog2(CAPACITY);

    logic [AW-1:0]          link_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_addr] <= link_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_link <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.val_we)
        begin
            val_mem[val_addr] <= val_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_val <= val_mem[rd_addr];
        end
    end

endmodule

// ===== src/colist_out.sv =====
`timescale 1ns / 1ps

module colist_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  colist_pkg::result_t res,
    output logic                space,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // element_value[31:0], length[37:32]
    output logic [2:0]          m_axis_tuser,   // status[2:0]
    output logic                m_axis_tlast
);

    logic                valid_reg;
    colist_pkg::result_t data_reg;

    // A new result may enter when the stage is empty or drains this cycle.
    assign space = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, data_reg.length, data_reg.element_value};
    assign m_axis_tuser  = data_reg.status;
    assign m_axis_tlast  = data_reg.last_of_run;

endmodule

// ===== src/circular_ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
//  channel   direction  payload
//  s_axis    in         tuser: opcode; tdata: position, item_value
//  m_axis    out        tuser: status; tdata: element_value, length; tlast: last_of_run
//
//  One command at a time. After the transfer, insert and delete walk k links from the tail
//  (k up to CAPACITY - 1), and an insert may first take its slot off the free chain; search
//  walks up to the n elements and dump walks all n of them. The slot memory has a single
//  read port, which paces each link walked.
//  Reset clears the tail, count, free chain and high-water mark; no clearing pass.
//  A stalled result output holds the sequencer only when it has a new result to hand over.

`include "circular_ordered_list_engine_core_defines.svh"

module circular_ordered_list_engine_core #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], item_value[39:8]
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // element_value[31:0], length[37:32]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int JW = (CW > 8) ? CW + 1 : 9;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DEC   = 14'b00000000000010,
        S_FTAKE = 14'b00000000000100,
        S_PLACE = 14'b00000000001000,
        S_WCHK  = 14'b00000000010000,
        S_WEV   = 14'b00000000100000,
        S_INEXT = 14'b00000001000000,
        S_ILINK = 14'b00000010000000,
        S_DNX1  = 14'b00000100000000,
        S_DNX2  = 14'b00001000000000,
        S_FREE  = 14'b00010000000000,
        S_SRD   = 14'b00100000000000,
        S_SEV   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t                  state_reg, state_next;
    colist_pkg::opcode_t     op_reg, op_next;
    logic [7:0]              pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           fhead_reg, fhead_next;
    logic [CW-1:0]           fcnt_reg, fcnt_next;
    logic [CW-1:0]           hwm_reg, hwm_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           snew_reg, snew_next;
    logic [AW-1:0]           dslot_reg, dslot_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    tflag_reg, tflag_next;
    logic [2:0]              res_status_reg, res_status_next;

    colist_pkg::mem_ctl_t    mctl;
    logic [AW-1:0]           rd_addr, link_addr, link_wdata;
    logic [AW-1:0]           rd_link;
    logic [VALUE_WIDTH-1:0]  rd_val;

    logic                    emit;
    colist_pkg::result_t     emit_res;
    logic                    space;

    logic signed [31:0]      in_val;
    logic [JW-1:0]           pos_w, cnt_w, pm1_w;

    assign in_val = s_axis_tdata[39:8];
    assign pos_w  = JW'(pos_reg);
    assign cnt_w  = JW'(count_reg);
    assign pm1_w  = pos_w - JW'(1);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        fhead_next      = fhead_reg;
        fcnt_next       = fcnt_reg;
        hwm_next        = hwm_reg;
        cur_next        = cur_reg;
        snew_next       = snew_reg;
        dslot_next      = dslot_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        tflag_next      = tflag_reg;
        res_status_next = res_status_reg;
        mctl            = '0;
        rd_addr         = cur_reg;
        link_addr       = cur_reg;
        link_wdata      = snew_reg;
        emit            = 1'b0;
        emit_res.status        = res_status_reg;
        emit_res.element_value = '0;
        emit_res.last_of_run   = 1'b1;
        emit_res.length        = 6'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = colist_pkg::opcode_t'(s_axis_tuser);
                    pos_next   = s_axis_tdata[7:0];
                    val_next   = VALUE_WIDTH'(in_val);
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cur_next = tail_reg;
                case (op_reg)
                    colist_pkg::OP_INS_FRONT, colist_pkg::OP_INS_END,
                    colist_pkg::OP_INS_POS:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = colist_pkg::ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else if (fcnt_reg != '0)
                        begin
                            mctl.rd_en = 1'b1;
                            rd_addr    = fhead_reg;
                            state_next = S_FTAKE;
                        end
                        else
                        begin
                            snew_next  = hwm_reg[AW-1:0];
                            hwm_next   = hwm_reg + CW'(1);
                            state_next = S_PLACE;
                        end
                    end
                    colist_pkg::OP_DEL_FRONT, colist_pkg::OP_DEL_END,
                    colist_pkg::OP_DEL_POS:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = colist_pkg::ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            if (op_reg == colist_pkg::OP_DEL_END)
                            begin
                                rem_next = count_reg - CW'(1);
                            end
                            else if (op_reg == colist_pkg::OP_DEL_POS && pos_w > JW'(1)
                                     && pos_w <= cnt_w)
                            begin
                                rem_next = CW'(pm1_w);
                            end
                            else
                            begin
                                rem_next = '0;
                            end
                            state_next = S_WCHK;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = colist_pkg::ST_NOT_FOUND;
                            state_next = (op_reg == colist_pkg::OP_SEARCH) ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            // One step from the tail lands on the head.
                            rem_next   = CW'(1);
                            idx_next   = count_reg;
                            state_next = S_WCHK;
                        end
                    end
                endcase
            end
            S_FTAKE:
            begin
                snew_next  = fhead_reg;
                fhead_next = rd_link;
                fcnt_next  = fcnt_reg - CW'(1);
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                mctl.val_we = 1'b1;
                cur_next    = tail_reg;
                if (count_reg == '0)
                begin
                    mctl.link_we    = 1'b1;
                    link_addr       = snew_reg;
                    link_wdata      = snew_reg;
                    tail_next       = snew_reg;
                    count_next      = CW'(1);
                    res_status_next = colist_pkg::ST_DONE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    // The new slot goes after the element reached by rem links from the tail.
                    rem_next   = '0;
                    tflag_next = (op_reg == colist_pkg::OP_INS_END);
                    if (op_reg == colist_pkg::OP_INS_POS && pos_w > JW'(1))
                    begin
                        if (pm1_w >= cnt_w)
                        begin
                            rem_next   = count_reg;
                            tflag_next = 1'b1;
                        end
                        else
                        begin
                            rem_next = CW'(pm1_w);
                        end
                    end
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (rem_reg != '0)
                begin
                    mctl.rd_en = 1'b1;
                    state_next = S_WEV;
                end
                else
                begin
                    case (op_reg)
                        colist_pkg::OP_INS_FRONT, colist_pkg::OP_INS_END,
                        colist_pkg::OP_INS_POS:
                        begin
                            mctl.rd_en = 1'b1;
                            state_next = S_INEXT;
                        end
                        colist_pkg::OP_DEL_FRONT, colist_pkg::OP_DEL_END,
                        colist_pkg::OP_DEL_POS:
                        begin
                            mctl.rd_en = 1'b1;
                            state_next = S_DNX1;
                        end
                        default:
                        begin
                            state_next = S_SRD;
                        end
                    endcase
                end
            end
            S_WEV:
            begin
                cur_next   = rd_link;
                rem_next   = rem_reg - CW'(1);
                state_next = S_WCHK;
            end
            S_INEXT:
            begin
                mctl.link_we = 1'b1;
                link_addr    = snew_reg;
                link_wdata   = rd_link;
                state_next   = S_ILINK;
            end
            S_ILINK:
            begin
                mctl.link_we = 1'b1;
                link_addr    = cur_reg;
                link_wdata   = snew_reg;
                if (tflag_reg)
                begin
                    tail_next = snew_reg;
                end
                count_next      = count_reg + CW'(1);
                res_status_next = colist_pkg::ST_DONE;
                state_next      = S_EMIT;
            end
            S_DNX1:
            begin
                dslot_next = rd_link;
                mctl.rd_en = 1'b1;
                rd_addr    = rd_link;
                state_next = S_DNX2;
            end
            S_DNX2:
            begin
                mctl.link_we = 1'b1;
                link_addr    = cur_reg;
                link_wdata   = rd_link;
                if (dslot_reg == tail_reg)
                begin
                    tail_next = cur_reg;
                end
                state_next = S_FREE;
            end
            S_FREE:
            begin
                // The removed slot goes on top of the free chain.
                mctl.link_we    = 1'b1;
                link_addr       = dslot_reg;
                link_wdata      = fhead_reg;
                fhead_next      = dslot_reg;
                fcnt_next       = fcnt_reg + CW'(1);
                count_next      = count_reg - CW'(1);
                res_status_next = colist_pkg::ST_DONE;
                state_next      = S_EMIT;
            end
            S_SRD:
            begin
                mctl.rd_en = 1'b1;
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (op_reg == colist_pkg::OP_SEARCH)
                begin
                    if (rd_val == val_reg)
                    begin
                        res_status_next = colist_pkg::ST_FOUND;
                        state_next      = S_EMIT;
                    end
                    else if (idx_reg == CW'(1))
                    begin
                        res_status_next = colist_pkg::ST_NOT_FOUND;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - CW'(1);
                        cur_next   = rd_link;
                        state_next = S_SRD;
                    end
                end
                else if (space)
                begin
                    emit                   = 1'b1;
                    emit_res.status        = colist_pkg::ST_DUMPED;
                    emit_res.element_value = 32'(rd_val);
                    emit_res.last_of_run   = (idx_reg == CW'(1));
                    if (idx_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - CW'(1);
                        cur_next   = rd_link;
                        state_next = S_SRD;
                    end
                end
            end
            S_EMIT:
            begin
                if (space)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_reg  <= '0;
            count_reg <= '0;
            fhead_reg <= '0;
            fcnt_reg  <= '0;
            hwm_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fhead_reg <= fhead_next;
            fcnt_reg  <= fcnt_next;
            hwm_reg   <= hwm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        snew_reg       <= snew_next;
        dslot_reg      <= dslot_next;
        rem_reg        <= rem_next;
        idx_reg        <= idx_next;
        tflag_reg      <= tflag_next;
        res_status_reg <= res_status_next;
    end

    colist_mem #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk        (clk),
        .ctl        (mctl),
        .rd_addr    (rd_addr),
        .link_addr  (link_addr),
        .link_wdata (link_wdata),
        .val_addr   (snew_reg),
        .val_wdata  (val_reg),
        .rd_link    (rd_link),
        .rd_val     (rd_val)
    );

    colist_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .res           (emit_res),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Between commands every slot is either in the list, on the free chain or never used.
    `COL_ASSERT(a_slot_conservation,
        (state_reg == S_IDLE) |-> ((32'(count_reg) + 32'(fcnt_reg) + 32'(CAPACITY)
            - 32'(hwm_reg)) == 32'(CAPACITY)),
        "slot accounting broken")
    `COL_ASSERT(a_scan_index_live, (state_reg == S_SEV) |-> (idx_reg != '0),
        "scan ran past the list")
    `COL_ASSERT(a_no_port_clash,
        !(mctl.rd_en && mctl.link_we && rd_addr == link_addr),
        "read and link write hit one slot together")

endmodule
